// ===== sv/jks_pkg.sv =====
// Shared types, codes and helpers for the JSON key string unescaper.
// No dependencies; the top level and the testbench files import this package.
package jks_pkg;

  localparam int unsigned KeyMaxCharsDef = 8;
  localparam int unsigned KeyTextW       = 64;
  localparam int unsigned MaxRes         = 8;

  // Configuration register indexes
  localparam logic RegKeyText   = 1'b0;
  localparam logic RegKeyLength = 1'b1;

  // Result kinds
  localparam logic [2:0] KindByte   = 3'd0;
  localparam logic [2:0] KindClosed = 3'd1;
  localparam logic [2:0] KindAbsent = 3'd2;
  localparam logic [2:0] KindNotStr = 3'd3;
  localparam logic [2:0] KindEnded  = 3'd4;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5c;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       out_last;
  } out_item_t;

  // Up to MaxRes results caused by one input byte
  typedef struct packed {
    out_item_t [MaxRes-1:0] r;
    logic [3:0]             n;
  } bundle_t;

  // Append one result; drop it once the bundle is full
  function automatic bundle_t push(bundle_t b, logic [7:0] v, logic [2:0] k, logic l);
    bundle_t o;
    o = b;
    if (b.n < 4'(MaxRes)) begin
      o.r[b.n[2:0]].out_byte = (k == KindByte) ? v : 8'h00;
      o.r[b.n[2:0]].kind     = k;
      o.r[b.n[2:0]].out_last = l;
      o.n                    = b.n + 4'd1;
    end
    return o;
  endfunction

  // Append the UTF-8 encoding of a code point
  function automatic bundle_t push_cp(bundle_t b, logic [20:0] cp);
    bundle_t o;
    o = b;
    if (cp <= 21'h7f) begin
      o = push(o, cp[7:0], KindByte, 1'b0);
    end else if (cp <= 21'h7ff) begin
      o = push(o, {3'b110, cp[10:6]}, KindByte, 1'b0);
      o = push(o, {2'b10, cp[5:0]}, KindByte, 1'b0);
    end else if (cp <= 21'hffff) begin
      o = push(o, {4'b1110, cp[15:12]}, KindByte, 1'b0);
      o = push(o, {2'b10, cp[11:6]}, KindByte, 1'b0);
      o = push(o, {2'b10, cp[5:0]}, KindByte, 1'b0);
    end else begin
      o = push(o, {5'b11110, cp[20:18]}, KindByte, 1'b0);
      o = push(o, {2'b10, cp[17:12]}, KindByte, 1'b0);
      o = push(o, {2'b10, cp[11:6]}, KindByte, 1'b0);
      o = push(o, {2'b10, cp[5:0]}, KindByte, 1'b0);
    end
    return o;
  endfunction

  // Hex digit value, bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_of(logic [7:0] b);
    logic [4:0] h;
    h = 5'd0;
    if (b >= 8'h30 && b <= 8'h39)      h = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) h = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) h = {1'b1, 4'(b - 8'h37)};
    return h;
  endfunction

endpackage

// ===== sv/jks_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is given by the instantiating level.
interface jks_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/jks_cell.sv =====
// One byte cell of the key marker window: holds a byte, hands it on, compares.
// Depends on nothing but its ports.
module jks_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] expect_i,
  input  logic       care_i,
  output logic [7:0] byte_o,
  output logic       match_o
);
  logic [7:0] byte_q, byte_d;

  // Take the neighbor byte on shift, drop everything at end of text
  always_comb begin
    byte_d = byte_q;
    if (shift_i) byte_d = byte_i;
    if (clear_i) byte_d = 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) byte_q <= 8'h00;
    else         byte_q <= byte_d;
  end

  // Compare the byte this cell is about to hold
  assign match_o = !care_i || (byte_i == expect_i);
  assign byte_o  = byte_q;
endmodule

// ===== sv/json_key_string_unescape.sv =====
// JSON key lookup and string value unescaper (top level).
// Depends on jks_pkg, jks_stream_if and jks_cell.
//
// Usage: bytes of a JSON text arrive on in_ch, one per transfer, in_last on
// the final byte. Key text and length are written on the cfg port while idle.
// A row of byte cells holds the recent bytes and matches the quoted key.
// Once found, the string value after the colon is decoded to UTF-8 bytes on
// out_ch; each text ends with exactly one terminal result (out_last set).
// Results of a byte are registered and appear on out_ch the cycle after its transfer.
// Input takes one byte per cycle while each byte yields at most one result
// and out_ch does not stall. A byte that yields n results (escapes, flushes)
// holds in_ch until the single result register, draining one result per cycle, is through.
// A byte with no result does not hold in_ch. A stall on out_ch holds the result
// register and backs up into in_ch. Reset clears the window, the decode
// state and the registers (key length 0, empty key text).
module json_key_string_unescape
  import jks_pkg::*;
#(
  parameter int unsigned KEY_MAX_CHARS = jks_pkg::KeyMaxCharsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [jks_pkg::KeyTextW-1:0]  cfg_data_i,
  jks_stream_if.sink                    in_ch,
  jks_stream_if.source                  out_ch
);
  localparam int unsigned Depth = KEY_MAX_CHARS + 2;
  localparam int unsigned LenW  = $clog2(KEY_MAX_CHARS + 1);

  typedef enum logic [2:0] {
    PhSearch, PhColon, PhSpace, PhValue, PhDone
  } phase_e;

  typedef enum logic [2:0] {
    EsNone, EsBsl, EsHex1, EsPairBsl, EsPairU, EsHex2
  } esc_e;

  // Configuration
  logic [KeyTextW-1:0] key_text_q;
  logic [3:0]          key_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q <= '0;
      key_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegKeyText:   key_text_q <= cfg_data_i;
        RegKeyLength: key_len_q  <= cfg_data_i[3:0];
        default:      ;
      endcase
    end
  end

  logic [LenW-1:0] eff_len;
  assign eff_len = (key_len_q > 4'(KEY_MAX_CHARS)) ? LenW'(KEY_MAX_CHARS) : LenW'(key_len_q);

  // Decode state
  phase_e      ph_q, ph_d;
  esc_e        es_q, es_d;
  logic [15:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [9:0]  held_q, held_d;
  logic        hv_q, hv_d;
  logic [3:0][7:0] tk_q, tk_d;

  // Result register
  bundle_t    bnd_q, bnd_d;
  logic [3:0] idx_q;
  logic       busy, in_xfer, out_xfer;

  assign busy     = {1'b0, idx_q} < {1'b0, bnd_q.n};
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !busy || (out_xfer && (idx_q + 4'd1 == bnd_q.n));
  assign in_xfer  = in_ch.valid && in_ch.ready;

  // Marker window cells
  logic [Depth-1:0][7:0] win;
  logic [Depth-1:0][7:0] expect_b;
  logic [Depth-1:0]      care, match;
  logic                  shift, clear;

  assign shift = in_xfer && (ph_q == PhSearch);
  assign clear = in_xfer && in_ch.payload.in_last;

  // Expected byte of each cell for the current key length
  always_comb begin
    for (int p = 0; p < Depth; p++) begin
      int base;
      base        = KEY_MAX_CHARS - int'(eff_len);
      expect_b[p] = ChQuote;
      care[p]     = 1'b1;
      if (p < base) begin
        care[p] = 1'b0;
      end else if (p > base && p < Depth - 1) begin
        expect_b[p] = key_text_q[8*(3'(p - base - 1)) +: 8];
      end
    end
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [7:0] nb;
    if (g == Depth - 1) begin : g_in
      assign nb = in_ch.payload.in_byte;
    end else begin : g_mid
      assign nb = win[g+1];
    end
    jks_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .clear_i  (clear),
      .byte_i   (nb),
      .expect_i (expect_b[g]),
      .care_i   (care[g]),
      .byte_o   (win[g]),
      .match_o  (match[g])
    );
  end

  // Next decode state and results for one byte
  always_comb begin
    logic [7:0]  b;
    logic [4:0]  h;
    logic        do_plain, do_esc, do_got, put_held, put_dig;
    logic [15:0] gcp;
    logic [7:0]  m;
    b        = in_ch.payload.in_byte;
    h        = hex_of(b);
    ph_d     = ph_q;
    es_d     = es_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    held_d   = held_q;
    hv_d     = hv_q;
    tk_d     = tk_q;
    bnd_d    = '0;
    do_plain = 1'b0;
    do_esc   = 1'b0;
    do_got   = 1'b0;
    put_held = 1'b0;
    put_dig  = 1'b0;
    gcp      = '0;
    m        = b;

    case (ph_q)
      PhSearch: if (&match) ph_d = PhColon;
      PhColon:  if (b == 8'h3a) ph_d = PhSpace;
      PhSpace: begin
        if (b == ChQuote) begin
          ph_d = PhValue;
        end else if (!(b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d)) begin
          bnd_d = push(bnd_d, 8'h00, KindNotStr, 1'b1);
          ph_d  = PhDone;
        end
      end
      PhValue: begin
        case (es_q)
          EsBsl: do_esc = 1'b1;
          EsHex1, EsHex2: begin
            if (h[4]) begin
              tk_d[cnt_q[1:0]] = b;
              acc_d = {acc_q[11:0], h[3:0]};
              cnt_d = cnt_q + 3'd1;
              if (cnt_d >= 3'd4) begin
                if (es_q == EsHex2 && acc_d >= 16'hdc00 && acc_d <= 16'hdfff) begin
                  bnd_d = push_cp(bnd_d, 21'h10000 + {1'b0, held_q, acc_d[9:0]});
                  hv_d   = 1'b0;
                  held_d = '0;
                  cnt_d  = '0;
                  acc_d  = '0;
                  es_d   = EsNone;
                end else begin
                  put_held = (es_q == EsHex2);
                  do_got   = 1'b1;
                  gcp      = acc_d;
                end
              end
            end else begin
              put_held = (es_q == EsHex2);
              put_dig  = 1'b1;
              do_plain = 1'b1;
            end
          end
          EsPairBsl: begin
            if (b == ChBsl) es_d = EsPairU;
            else begin
              put_held = 1'b1;
              do_plain = 1'b1;
            end
          end
          EsPairU: begin
            if (b == 8'h75) begin
              es_d  = EsHex2;
              cnt_d = '0;
              acc_d = '0;
            end else begin
              put_held = 1'b1;
              do_esc   = 1'b1;
            end
          end
          default: do_plain = 1'b1;
        endcase
      end
      default: ;
    endcase

    // Flush a held high surrogate, then taken digits
    if (put_held) begin
      if (hv_q) bnd_d = push_cp(bnd_d, {5'd0, 6'b110110, held_q});
      hv_d   = 1'b0;
      held_d = '0;
    end
    if (put_dig) begin
      for (int i = 0; i < 4; i++)
        if (3'(i) < cnt_q) bnd_d = push(bnd_d, tk_q[i], KindByte, 1'b0);
      cnt_d = '0;
      acc_d = '0;
    end

    // Completed code point: hold a high surrogate, else encode
    if (do_got) begin
      cnt_d = '0;
      acc_d = '0;
      if (gcp >= 16'hd800 && gcp <= 16'hdbff) begin
        held_d = gcp[9:0];
        hv_d   = 1'b1;
        es_d   = EsPairBsl;
      end else begin
        bnd_d = push_cp(bnd_d, {5'd0, gcp});
        es_d  = EsNone;
      end
    end

    // Escaped character
    if (do_esc) begin
      es_d = EsNone;
      case (b)
        8'h62: m = 8'h08;
        8'h66: m = 8'h0c;
        8'h6e: m = 8'h0a;
        8'h72: m = 8'h0d;
        8'h74: m = 8'h09;
        default: m = b;
      endcase
      if (b == 8'h75) begin
        es_d  = EsHex1;
        cnt_d = '0;
        acc_d = '0;
      end else begin
        bnd_d = push(bnd_d, m, KindByte, 1'b0);
      end
    end

    // Ordinary value byte
    if (do_plain) begin
      es_d = EsNone;
      if (b == ChQuote) begin
        bnd_d = push(bnd_d, 8'h00, KindClosed, 1'b1);
        ph_d  = PhDone;
      end else if (b == ChBsl) begin
        es_d = EsBsl;
      end else begin
        bnd_d = push(bnd_d, b, KindByte, 1'b0);
      end
    end

    // End of text: flush what is pending, report unless done, start over
    if (in_ch.payload.in_last) begin
      case (ph_d)
        PhSearch: bnd_d = push(bnd_d, 8'h00, KindAbsent, 1'b1);
        PhColon, PhSpace: bnd_d = push(bnd_d, 8'h00, KindNotStr, 1'b1);
        PhValue: begin
          if ((es_d == EsPairBsl || es_d == EsPairU || es_d == EsHex2) && hv_d)
            bnd_d = push_cp(bnd_d, {5'd0, 6'b110110, held_d});
          if (es_d == EsHex1 || es_d == EsHex2)
            for (int i = 0; i < 4; i++)
              if (3'(i) < cnt_d) bnd_d = push(bnd_d, tk_d[i], KindByte, 1'b0);
          bnd_d = push(bnd_d, 8'h00, KindEnded, 1'b1);
        end
        default: ;
      endcase
      ph_d   = PhSearch;
      es_d   = EsNone;
      acc_d  = '0;
      cnt_d  = '0;
      held_d = '0;
      hv_d   = 1'b0;
      tk_d   = '0;
    end
  end

  // Hold decode state, advance on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhSearch;
      es_q   <= EsNone;
      acc_q  <= '0;
      cnt_q  <= '0;
      held_q <= '0;
      hv_q   <= 1'b0;
      tk_q   <= '0;
    end else if (in_xfer) begin
      ph_q   <= ph_d;
      es_q   <= es_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
      hv_q   <= hv_d;
      tk_q   <= tk_d;
    end
  end

  // Result register: load on input transfer, step through on output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q <= '0;
      idx_q <= '0;
    end else if (in_xfer) begin
      bnd_q <= bnd_d;
      idx_q <= '0;
    end else if (out_xfer) begin
      idx_q <= idx_q + 4'd1;
    end
  end

  assign out_ch.valid   = busy;
  assign out_ch.payload = bnd_q.r[idx_q[2:0]];

  // A pending result that is not taken holds off new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

  // A terminal kind always carries the last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.payload.kind != KindByte |-> out_ch.payload.out_last)
    else $error("terminal result without last flag");

  // A held surrogate exists only while a pair may still complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv_q |-> (es_q == EsPairBsl || es_q == EsPairU || es_q == EsHex2))
    else $error("held surrogate in wrong escape stage");

  // Four digits always complete a code point at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 3'd4)
    else $error("hex digit count overflow");
endmodule

// ===== tb/tb_stream_if.sv =====
// Testbench copy of nothing: the stream interface comes from the RTL (jks_stream_if).
// This file holds the small testbench helper package; it depends on jks_pkg.
package tb_jks_pkg;
  import jks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Decoder phases and escape stages of the predictor
  typedef enum logic [2:0] {
    PhSearch, PhColon, PhSpace, PhValue, PhDone
  } phase_e;

  typedef enum logic [2:0] {
    EsNone, EsBsl, EsHex1, EsPairBsl, EsPairU, EsHex2
  } esc_e;

  // One row of the directed table
  typedef struct {
    logic [7:0] b;
    logic       l;
  } stim_row_t;
endpackage

// ===== tb/testbench.sv =====
// Self-checking testbench for json_key_string_unescape.
// Depends on jks_pkg, jks_stream_if, tb_jks_pkg and the RTL top level.
// Directed texts then random JSON texts, checked against a built-in decoder model.
module testbench;
  import jks_pkg::*;
  import tb_jks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = RegKeyText;
  logic [63:0] cfg_data_i = '0;

  jks_stream_if #(.T(in_item_t))  in_ch ();
  jks_stream_if #(.T(out_item_t)) out_ch ();

  json_key_string_unescape u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("json_key_string_unescape: mismatch");
    $finish;
  end

  // Decoder model state
  logic [63:0] key_txt;
  logic [3:0]  key_len;
  logic [7:0]  win [10];
  phase_e      ph;
  esc_e        esc;
  logic [15:0] acc;
  int          ndig;
  logic [9:0]  hi_sur;
  logic        hi_ok;
  logic [7:0]  digs [4];

  out_item_t   expected_q[$];
  int          n_err = 0;
  bit          hold_off = 1'b0;

  task automatic emit(logic [7:0] v, logic [2:0] k, logic l);
    out_item_t r;
    r.out_byte = (k == KindByte) ? v : 8'h00;
    r.kind = k;
    r.out_last = l;
    expected_q = {expected_q, r};
  endtask

  task automatic emit_cp(logic [20:0] cp);
    if (cp <= 21'h7f) begin
      emit(cp[7:0], KindByte, 1'b0);
    end else if (cp <= 21'h7ff) begin
      emit({3'b110, cp[10:6]}, KindByte, 1'b0);
      emit({2'b10, cp[5:0]}, KindByte, 1'b0);
    end else if (cp <= 21'hffff) begin
      emit({4'b1110, cp[15:12]}, KindByte, 1'b0);
      emit({2'b10, cp[11:6]}, KindByte, 1'b0);
      emit({2'b10, cp[5:0]}, KindByte, 1'b0);
    end else begin
      emit({5'b11110, cp[20:18]}, KindByte, 1'b0);
      emit({2'b10, cp[17:12]}, KindByte, 1'b0);
      emit({2'b10, cp[11:6]}, KindByte, 1'b0);
      emit({2'b10, cp[5:0]}, KindByte, 1'b0);
    end
  endtask

  function automatic int hexval(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  task automatic clear_text();
    foreach (win[i]) win[i] = 8'h00;
    foreach (digs[i]) digs[i] = 8'h00;
    ph = PhSearch; esc = EsNone; acc = '0; ndig = 0; hi_sur = '0; hi_ok = 1'b0;
  endtask

  task automatic drop_held();
    if (hi_ok) emit_cp(21'hd800 + hi_sur);
    hi_ok = 1'b0; hi_sur = '0;
  endtask

  task automatic drop_digits();
    for (int i = 0; i < ndig && i < 4; i++) emit(digs[i], KindByte, 1'b0);
    ndig = 0; acc = '0;
  endtask

  task automatic plain(logic [7:0] b);
    esc = EsNone;
    if (b == ChQuote) begin
      emit(8'h00, KindClosed, 1'b1); ph = PhDone;
    end else if (b == ChBsl) esc = EsBsl;
    else emit(b, KindByte, 1'b0);
  endtask

  task automatic escaped(logic [7:0] b);
    logic [7:0] m;
    m = b; esc = EsNone;
    case (b)
      "b": m = 8'h08;
      "f": m = 8'h0c;
      "n": m = 8'h0a;
      "r": m = 8'h0d;
      "t": m = 8'h09;
      "u": begin
        esc = EsHex1; ndig = 0; acc = '0;
        return;
      end
      default: ;
    endcase
    emit(m, KindByte, 1'b0);
  endtask

  task automatic code_point(logic [15:0] cp);
    ndig = 0; acc = '0;
    if (cp >= 16'hd800 && cp <= 16'hdbff) begin
      hi_sur = cp[9:0]; hi_ok = 1'b1; esc = EsPairBsl;
    end else begin
      emit_cp({5'd0, cp}); esc = EsNone;
    end
  endtask

  function automatic bit take(logic [7:0] b);
    int h;
    h = hexval(b);
    if (h < 0) return 0;
    digs[ndig & 3] = b;
    acc = {acc[11:0], 4'(h)};
    ndig++;
    return 1;
  endfunction

  task automatic value_step(logic [7:0] b);
    logic [15:0] lo;
    case (esc)
      EsBsl: escaped(b);
      EsHex1: begin
        if (take(b)) begin
          if (ndig >= 4) code_point(acc);
        end else begin
          drop_digits(); plain(b);
        end
      end
      EsPairBsl: begin
        if (b == ChBsl) esc = EsPairU;
        else begin
          drop_held(); plain(b);
        end
      end
      EsPairU: begin
        if (b == "u") begin
          esc = EsHex2; ndig = 0; acc = '0;
        end else begin
          drop_held(); escaped(b);
        end
      end
      EsHex2: begin
        if (take(b)) begin
          if (ndig >= 4) begin
            lo = acc;
            if (lo >= 16'hdc00 && lo <= 16'hdfff) begin
              emit_cp(21'h10000 + {hi_sur, lo[9:0]});
              hi_ok = 1'b0; hi_sur = '0; ndig = 0; acc = '0; esc = EsNone;
            end else begin
              drop_held(); code_point(lo);
            end
          end
        end else begin
          drop_held(); drop_digits(); plain(b);
        end
      end
      default: plain(b);
    endcase
  endtask

  function automatic bit key_seen();
    int len, base;
    len = (key_len > 8) ? 8 : key_len;
    base = 10 - (len + 2);
    if (win[base] != ChQuote || win[9] != ChQuote) return 0;
    for (int i = 0; i < len; i++)
      if (win[base + 1 + i] != key_txt[8*i +: 8]) return 0;
    return 1;
  endfunction

  // Predict the results of one accepted byte
  task automatic predict_byte(in_item_t it);
    case (ph)
      PhSearch: begin
        for (int i = 0; i < 9; i++) win[i] = win[i+1];
        win[9] = it.in_byte;
        if (key_seen()) ph = PhColon;
      end
      PhColon: if (it.in_byte == ":") ph = PhSpace;
      PhSpace: begin
        if (it.in_byte == ChQuote) ph = PhValue;
        else if (!(it.in_byte inside {8'h20, 8'h09, 8'h0a, 8'h0d})) begin
          emit(8'h00, KindNotStr, 1'b1); ph = PhDone;
        end
      end
      PhValue: value_step(it.in_byte);
      default: ;
    endcase
    if (it.in_last) begin
      if (ph == PhSearch) emit(8'h00, KindAbsent, 1'b1);
      else if (ph == PhColon || ph == PhSpace) emit(8'h00, KindNotStr, 1'b1);
      else if (ph == PhValue) begin
        if (esc == EsPairBsl || esc == EsPairU) drop_held();
        else if (esc == EsHex1) drop_digits();
        else if (esc == EsHex2) begin
          drop_held(); drop_digits();
        end
        emit(8'h00, KindEnded, 1'b1);
      end
      clear_text();
    end
  endtask

  // Stimulus pending for the sender
  in_item_t byte_q[$];

  task automatic push_text(string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.in_byte = s[i];
      it.in_last = (i == s.len() - 1);
      byte_q = {byte_q, it};
    end
  endtask

  // Sender: bursts and gaps; predict at each transfer
  initial begin
    int burst;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.payload);
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (byte_q.size() > 0 && burst > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.payload <= byte_q.pop_front();
          burst--;
        end else begin
          in_ch.valid <= 1'b0;
          if (burst == 0 && $urandom_range(0, 3) == 0) burst = $urandom_range(1, 20);
          else if (burst == 0 && $urandom_range(0, 1)) burst = 0;
          else if (burst == 0) burst = $urandom_range(1, 4);
        end
      end
    end
  end

  // Receiver: stall pattern plus a long hold-off; check each transfer
  initial begin
    out_item_t got, exp;
    int mode;
    out_ch.ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result byte=%h kind=%0d last=%0d",
                                    got.out_byte, got.kind, got.out_last);
        end else begin
          exp = expected_q.pop_front();
          if (got !== exp) begin
            n_err++;
            if (n_err <= 10)
              $display("exp byte=%h kind=%0d last=%0d got byte=%h kind=%0d last=%0d",
                       exp.out_byte, exp.kind, exp.out_last,
                       got.out_byte, got.kind, got.out_last);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= $urandom_range(0, 1);
    end
  end

  task automatic write_reg(logic idx, logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegKeyText) key_txt = v;
    else key_len = v[3:0];
  endtask

  task automatic drain();
    while (byte_q.size() > 0 || in_ch.valid || expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic string rand_key(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("a", "z")))};
    return s;
  endfunction

  function automatic logic [63:0] pack_key(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // One random piece of value content
  function automatic string rand_piece();
    string hx, s;
    hx = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 9))
      0: return "\\n";
      1: return {"\\", string'(8'($urandom_range(32, 126)))};
      2: return $sformatf("\\u%04x", $urandom_range(0, 16'hffff));
      3: return $sformatf("\\u%04x\\u%04x", $urandom_range(16'hd800, 16'hdbff),
                          $urandom_range(16'hdc00, 16'hdfff));
      4: return $sformatf("\\u%04x", $urandom_range(16'hd800, 16'hdfff));
      5: begin
        s = "\\u";
        for (int i = 0; i < $urandom_range(0, 3); i++) s = {s, string'(hx[$urandom_range(0, 21)])};
        return {s, "z"};
      end
      6: return string'(8'($urandom_range(8'h80, 8'hff)));
      7: return $sformatf("\\u%04x\\%s", $urandom_range(16'hd800, 16'hdbff),
                          $urandom_range(0, 1) ? "x" : "u0041");
      default: return string'(8'($urandom_range(32, 126)));
    endcase
  endfunction

  function automatic string rand_text(string key);
    string s, v;
    int sel;
    sel = $urandom_range(0, 19);
    v = "";
    for (int i = 0; i < $urandom_range(0, 5); i++) v = {v, rand_piece()};
    case (sel)
      0: s = {"{\"zz\":1}"};
      1: s = {"{\"", key, "\": 12}"};
      2: s = {"{\"", key, "\" \t:\n \"", v};
      3: s = {"{\"", key, "\""};
      4: begin
        s = "";
        for (int i = 0; i < $urandom_range(1, 12); i++)
          s = {s, string'(8'($urandom_range(0, 255)))};
      end
      default: s = {"{\"a\":0,\"", key, "\" : \"", v, "\",\"", key, "\":\"q\"}"};
    endcase
    return s;
  endfunction

  // Directed rows: after-reset empty key texts and special cases
  stim_row_t dir_rows [21] = '{
    '{8'h00, 1'b1}, '{8'hff, 1'b1}, '{ChQuote, 1'b0}, '{ChQuote, 1'b0},
    '{":", 1'b0}, '{"5", 1'b1}, '{ChQuote, 1'b0}, '{ChQuote, 1'b0},
    '{":", 1'b0}, '{" ", 1'b0}, '{ChQuote, 1'b0}, '{"A", 1'b0},
    '{ChBsl, 1'b0}, '{"u", 1'b0}, '{"d", 1'b0}, '{"8", 1'b0},
    '{"0", 1'b0}, '{"0", 1'b1}, '{ChQuote, 1'b0}, '{ChQuote, 1'b0},
    '{":", 1'b1}
  };

  initial begin
    string key;
    string txt;
    in_item_t it;
    int nrand;
    clear_text();
    key_txt = '0; key_len = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      it.in_byte = dir_rows[i].b; it.in_last = dir_rows[i].l;
      byte_q = {byte_q, it};
    end
    drain();

    // Key lengths across the range, lengths 1, 8 and 15 always included
    nrand = 0;
    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      int kl;
      kl = (ph_i == 0) ? 8 : (ph_i == 1) ? 1 : (ph_i == 2) ? 15 : $urandom_range(0, 8);
      key = rand_key(kl > 8 ? 8 : kl);
      write_reg(RegKeyText, (ph_i == 3) ? 64'hffff_ffff_ffff_ffff : pack_key(key));
      write_reg(RegKeyLength, 64'(kl));
      if (ph_i == 3) key = {8{string'(8'hff)}};
      if (ph_i == 1) begin
        // Hold the receiver off while a text keeps coming
        push_text({"{\"", key, "\":\"\\ud83d\\ude00\\u00e9\\u20ac\"}"});
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      while (nrand < 280 * (ph_i + 1) / 6) begin
        txt = rand_text(key);
        push_text(txt);
        nrand += txt.len();
      end
      drain();
    end

    if (n_err == 0) $display("json_key_string_unescape: match");
    else $display("json_key_string_unescape: mismatch");
    $finish;
  end
endmodule
